// File: src/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// shared types, sizes and codes for the 2x2 averaging downscaler
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int CHANNEL_BITS    = 8;
  localparam int PAIR_BITS       = CHANNEL_BITS + 1;
  localparam int SUM_BITS        = CHANNEL_BITS + 2;
  localparam int LINE_DEPTH      = MAX_WIDTH / 2;
  localparam int SLOT_BITS       = $clog2(LINE_DEPTH);
  localparam int LINE_BITS       = 3 * PAIR_BITS;
  localparam int COUNT_BITS      = $clog2(MAX_WIDTH);
  localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS       = COUNT_BITS + 1;
  localparam int HSIZE_BITS      = ROW_BITS + 1;
  localparam int REG_BITS        = 11;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int CMD_PTR_BITS    = $clog2(CMD_QUEUE_DEPTH);
  localparam int OUT_QUEUE_DEPTH = 4;
  localparam int OUT_PTR_BITS    = $clog2(OUT_QUEUE_DEPTH);

  localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(640);
  localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(480);

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 1'b1;

  // command kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic                    row_end;
    logic                    frame_end;
  } result_t;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_BITS-1:0] slot;
    logic [PAIR_BITS-1:0] red_pair;
    logic [PAIR_BITS-1:0] green_pair;
    logic [PAIR_BITS-1:0] blue_pair;
    logic                 row_end;
    logic                 frame_end;
  } cmd_t;

  function automatic logic [SIZE_BITS-1:0] clamp_width(input logic [REG_BITS-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'd2) return SIZE_BITS'(2);
    else if (x > 32'(MAX_WIDTH)) return SIZE_BITS'(MAX_WIDTH);
    else return SIZE_BITS'(x);
  endfunction

  function automatic logic [HSIZE_BITS-1:0] clamp_height(input logic [REG_BITS-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'd2) return HSIZE_BITS'(2);
    else if (x > 32'(MAX_HEIGHT)) return HSIZE_BITS'(MAX_HEIGHT);
    else return HSIZE_BITS'(x);
  endfunction

endpackage

`default_nettype wire

// File: src/dsc_front.sv
// ----------------------------------------------------------------------------
// dsc_front
// size registers, raster position and pair summing; issues line commands
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_front import dsc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]       cfg_data,
  input  wire logic                      accept,
  input  wire pixel_t                    pixel,
  output logic                           cmd_push,
  output cmd_t                           cmd
);

  logic [REG_BITS-1:0]   image_width;
  logic [REG_BITS-1:0]   image_height;
  logic [COUNT_BITS-1:0] column_count;
  logic [ROW_BITS-1:0]   row_count;
  pixel_t                pending_left;

  logic [SIZE_BITS-1:0]  w, w_even, c_ext, c_plus;
  logic [HSIZE_BITS-1:0] h, h_even, r_ext, r_plus;
  logic                  in_band, cmd_valid;

  always_comb begin
    w       = clamp_width(image_width);
    h       = clamp_height(image_height);
    w_even  = {w[SIZE_BITS-1:1], 1'b0};
    h_even  = {h[HSIZE_BITS-1:1], 1'b0};
    c_ext   = SIZE_BITS'(column_count);
    r_ext   = HSIZE_BITS'(row_count);
    c_plus  = c_ext + SIZE_BITS'(1);
    r_plus  = r_ext + HSIZE_BITS'(1);
    in_band = c_ext < w_even;
    // odd column of a pair; even rows store, odd rows inside the frame emit
    cmd_valid = in_band && column_count[0] && (!row_count[0] || (r_ext < h_even));

    cmd.kind       = row_count[0] ? CMD_EMIT : CMD_WRITE;
    cmd.slot       = column_count[COUNT_BITS-1:1];
    cmd.red_pair   = PAIR_BITS'(pending_left.red_in) + PAIR_BITS'(pixel.red_in);
    cmd.green_pair = PAIR_BITS'(pending_left.green_in) + PAIR_BITS'(pixel.green_in);
    cmd.blue_pair  = PAIR_BITS'(pending_left.blue_in) + PAIR_BITS'(pixel.blue_in);
    cmd.row_end    = c_plus >= w_even;
    cmd.frame_end  = (c_plus >= w_even) && (r_plus >= h_even);
    cmd_push       = accept && cmd_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pending_left <= '0;
    end else if (accept) begin
      if (in_band && !column_count[0]) begin
        pending_left <= pixel;
      end
      if (c_plus >= w) begin
        column_count <= '0;
        row_count    <= (r_plus >= h) ? '0 : r_plus[ROW_BITS-1:0];
      end else begin
        column_count <= c_plus[COUNT_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/dsc_cmd_queue.sv
// ----------------------------------------------------------------------------
// dsc_cmd_queue
// short command queue between the front and the line store side
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_cmd_queue import dsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t                  entries [CMD_QUEUE_DEPTH];
  logic [CMD_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CMD_PTR_BITS:0]   count;
  logic                    do_push, do_pop;

  assign full    = count == (CMD_PTR_BITS+1)'(CMD_QUEUE_DEPTH);
  assign empty   = count == '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CMD_PTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + CMD_PTR_BITS'(1);
      if (do_push && !do_pop)      count <= count + (CMD_PTR_BITS+1)'(1);
      else if (do_pop && !do_push) count <= count - (CMD_PTR_BITS+1)'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/dsc_back.sv
// ----------------------------------------------------------------------------
// dsc_back
// line store of pair sums, block average and result queue
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_back import dsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd_head,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  input  wire logic pop,
  output logic      empty,
  output result_t   result
);

  logic [LINE_BITS-1:0] line_mem [LINE_DEPTH];
  logic [LINE_BITS-1:0] line_rdata;

  cmd_t                 s2;
  logic                 s2_valid;
  logic                 s2_go;
  logic                 out_space;
  result_t              s2_result;
  logic [SUM_BITS-1:0]  red_sum, green_sum, blue_sum;

  result_t                 out_q [OUT_QUEUE_DEPTH];
  logic [OUT_PTR_BITS-1:0] out_wr, out_rd;
  logic [OUT_PTR_BITS:0]   out_count;
  logic                    out_pop;

  assign out_space = out_count != (OUT_PTR_BITS+1)'(OUT_QUEUE_DEPTH);
  assign s2_go     = s2_valid && out_space;
  assign cmd_pop   = !cmd_empty && (!s2_valid || s2_go);
  assign empty     = out_count == '0;
  assign out_pop   = pop && !empty;
  assign result    = out_q[out_rd];

  // line store: write on even rows, registered read on odd rows
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd_head.kind == CMD_WRITE) begin
        line_mem[cmd_head.slot] <= {cmd_head.red_pair, cmd_head.green_pair,
                                    cmd_head.blue_pair};
      end else begin
        line_rdata <= line_mem[cmd_head.slot];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) s2 <= cmd_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (cmd_pop) begin
      s2_valid <= cmd_head.kind == CMD_EMIT;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_comb begin
    red_sum   = SUM_BITS'(line_rdata[3*PAIR_BITS-1:2*PAIR_BITS]) + SUM_BITS'(s2.red_pair);
    green_sum = SUM_BITS'(line_rdata[2*PAIR_BITS-1:PAIR_BITS]) + SUM_BITS'(s2.green_pair);
    blue_sum  = SUM_BITS'(line_rdata[PAIR_BITS-1:0]) + SUM_BITS'(s2.blue_pair);
    s2_result.red_out   = red_sum[SUM_BITS-1:2];
    s2_result.green_out = green_sum[SUM_BITS-1:2];
    s2_result.blue_out  = blue_sum[SUM_BITS-1:2];
    s2_result.row_end   = s2.row_end;
    s2_result.frame_end = s2.frame_end;
  end

  always_ff @(posedge clk) begin
    if (s2_go) out_q[out_wr] <= s2_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (s2_go)   out_wr <= out_wr + OUT_PTR_BITS'(1);
      if (out_pop) out_rd <= out_rd + OUT_PTR_BITS'(1);
      if (s2_go && !out_pop)      out_count <= out_count + (OUT_PTR_BITS+1)'(1);
      else if (out_pop && !s2_go) out_count <= out_count - (OUT_PTR_BITS+1)'(1);
    end
  end

  a_out_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_count <= (OUT_PTR_BITS+1)'(OUT_QUEUE_DEPTH))
    else $error("result queue over its depth");

  a_emit_fills_stage: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd_head.kind == CMD_EMIT |=> s2_valid)
    else $error("emit command lost before averaging");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_go |=> s2_valid && $stable(s2) && $stable(line_rdata))
    else $error("stalled averaging stage changed");

endmodule

`default_nettype wire

// File: src/pixel_downscale_2x2_average.sv
// ----------------------------------------------------------------------------
// pixel_downscale_2x2_average
// 2x2 box filter downscaler for a raster rgb stream
// ----------------------------------------------------------------------------
// Takes one source pixel per clock in raster order whenever push is high and
// full is low, and gives one pixel per 2x2 block, each channel the sum of
// four samples shifted right by two. Each block passes through the
// registered command queue, averaging stage and result queue. A steady
// stream runs at one item per clock while full stays low: the front takes
// a pixel every clock and the line store sees at most one write or one read
// for every two pixels. Even rows leave their pair sums in the line store;
// the odd column of the odd row below reads it back and emits, with row_end
// on the last result of an output row and frame_end (with row_end) on the
// last one of the frame. Odd trailing columns and rows are swallowed. Sizes
// are clamped to 2..1024 and should only be written while the block is idle.
`default_nettype none

module pixel_downscale_2x2_average import dsc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration writes
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]       cfg_data,
  // source pixel side
  input  wire logic                      push,
  output logic                           full,
  input  wire pixel_t                    pixel,
  // result side
  output logic                           empty,
  input  wire logic                      pop,
  output result_t                        result
);

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  // every pixel is taken while the command queue has room
  assign accept = push && !full;

  // front: counters, pending left pixel, pair sums
  dsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (pixel),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  // decouples the front from line store stalls
  dsc_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (full),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .empty    (cmd_empty)
  );

  // back: line store, averaging and result queue
  dsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 2x2 averaging downscaler
// ----------------------------------------------------------------------------
// Drives raster pixel streams through the block under a series of frame
// sizes and checks every emitted block average, row_end and frame_end flag
// against a cycle-free model of the downscaler kept in this bench. Both
// handshakes idle at random, the receiver holds off once for a long stretch
// so that the block stalls its input, and sizes change between phases and
// in the middle of a frame, where the width only ever shrinks.
// ----------------------------------------------------------------------------

module tb;
  import dsc_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 300;   // length of the long receiver hold-off
  localparam int SETTLE      = 8;     // pipeline depth allowance before register writes
  localparam int RANDOM_ITEMS = 250;
  localparam int PRESSURE_ITEMS = 200;

  // pair sums of one column pair, one per channel
  typedef struct packed {
    logic [PAIR_BITS-1:0] red;
    logic [PAIR_BITS-1:0] green;
    logic [PAIR_BITS-1:0] blue;
  } pair_sums_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WIDTH;
  logic [REG_BITS-1:0]       cfg_data = '0;
  logic                      push = 1'b0;
  logic                      full;
  pixel_t                    src_pixel = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  result_t                   out_pixel;

  // model state
  logic [REG_BITS-1:0] width_reg = WIDTH_RESET;
  logic [REG_BITS-1:0] height_reg = HEIGHT_RESET;
  pair_sums_t          even_row_sums [LINE_DEPTH];
  pixel_t              left_pixel = '0;
  int                  col_pos = 0;
  int                  row_pos = 0;

  result_t pending_averages[$];
  int      errors = 0;
  int      pixels_sent = 0;
  bit      no_idle = 1'b0;
  bit      hold_request = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  pixel_downscale_2x2_average DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel     (src_pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (out_pixel)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // model of the downscaler
  // --------------------------------------------------------------------------

  // sizes as the block sees them: clamped to 2..1024
  function automatic int active_width();
    int v;
    v = int'(width_reg);
    if (v < 2) return 2;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic int active_height();
    int v;
    v = int'(height_reg);
    if (v < 2) return 2;
    if (v > MAX_HEIGHT) return MAX_HEIGHT;
    return v;
  endfunction

  // one accepted source pixel: update position and line store, queue any average
  function automatic void predict_average(input pixel_t p);
    int         w_even;
    int         h_even;
    int         slot;
    pair_sums_t pair;
    logic [SUM_BITS-1:0] red_sum;
    logic [SUM_BITS-1:0] green_sum;
    logic [SUM_BITS-1:0] blue_sum;
    result_t    avg;
    w_even = active_width() & ~1;
    h_even = active_height() & ~1;
    // columns beyond the even part of the width are swallowed
    if (col_pos < w_even) begin
      if (col_pos % 2 == 0) begin
        left_pixel = p;
      end else begin
        slot = col_pos / 2;
        pair.red   = PAIR_BITS'(left_pixel.red_in)   + PAIR_BITS'(p.red_in);
        pair.green = PAIR_BITS'(left_pixel.green_in) + PAIR_BITS'(p.green_in);
        pair.blue  = PAIR_BITS'(left_pixel.blue_in)  + PAIR_BITS'(p.blue_in);
        if (row_pos % 2 == 0) begin
          even_row_sums[slot] = pair;
        end else if (row_pos < h_even) begin
          // odd row below a stored even row: finish the 2x2 block
          red_sum   = SUM_BITS'(even_row_sums[slot].red)   + SUM_BITS'(pair.red);
          green_sum = SUM_BITS'(even_row_sums[slot].green) + SUM_BITS'(pair.green);
          blue_sum  = SUM_BITS'(even_row_sums[slot].blue)  + SUM_BITS'(pair.blue);
          avg.red_out   = red_sum[SUM_BITS-1:2];
          avg.green_out = green_sum[SUM_BITS-1:2];
          avg.blue_out  = blue_sum[SUM_BITS-1:2];
          avg.row_end   = (col_pos + 1 >= w_even);
          avg.frame_end = avg.row_end && (row_pos + 1 >= h_even);
          pending_averages.push_back(avg);
        end
      end
    end
    // position wraps on the full size, odd trailing column and row included
    if (col_pos + 1 >= active_width()) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= active_height()) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // result side: random pop, long hold-off on request, checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected item, got %p", $time, out_pixel);
        errors++;
      end else begin
        want = pending_averages.pop_front();
        if (out_pixel.red_out !== want.red_out) begin
          $display("%0t: red_out expected %0d got %0d", $time, want.red_out,
                   out_pixel.red_out);
          errors++;
        end
        if (out_pixel.green_out !== want.green_out) begin
          $display("%0t: green_out expected %0d got %0d", $time, want.green_out,
                   out_pixel.green_out);
          errors++;
        end
        if (out_pixel.blue_out !== want.blue_out) begin
          $display("%0t: blue_out expected %0d got %0d", $time, want.blue_out,
                   out_pixel.blue_out);
          errors++;
        end
        if (out_pixel.row_end !== want.row_end) begin
          $display("%0t: row_end expected %0b got %0b", $time, want.row_end,
                   out_pixel.row_end);
          errors++;
        end
        if (out_pixel.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
                   out_pixel.frame_end);
          errors++;
        end
      end
    end
    // pop for the next edge
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  // watchdog: ends the run when no item moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, %0d averages outstanding", $time,
                 pending_averages.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic pixel_t rand_pixel();
    return pixel_t'(24'($urandom));
  endfunction

  // offer one pixel, with a random gap before it, and wait until it is taken
  task automatic send_pixel(input pixel_t p);
    while (!no_idle && $urandom_range(99) < 15) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    src_pixel <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_average(p);
    pixels_sent++;
  endtask

  // random pixels until the raster position is back at the top left corner
  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel());
  endtask

  task automatic send_frames(input int frames);
    repeat (frames) begin
      send_pixel(rand_pixel());
      finish_frame();
    end
  endtask

  // stop offering, let every average come out, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= REG_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WIDTH) width_reg = REG_BITS'(value);
    else height_reg = REG_BITS'(value);
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // hand-picked frames: channel extremes, truncation, odd width and height
  task automatic test_directed();
    set_size(4, 2);
    send_pixel('{8'd0,   8'd0,   8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0,   8'd128});
    send_pixel('{8'd1,   8'd2,   8'd3});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd0,   8'd0,   8'd0});
    send_pixel('{8'd3,   8'd255, 8'd0});
    send_pixel('{8'd2,   8'd1,   8'd255});
    // all four samples at full scale
    set_size(2, 2);
    repeat (4) send_pixel('{8'd255, 8'd255, 8'd255});
    // odd width and height: last column and last row give nothing
    set_size(3, 3);
    send_pixel('{8'd1,   8'd1,   8'd1});
    send_pixel('{8'd2,   8'd2,   8'd2});
    send_pixel('{8'd99,  8'd99,  8'd99});
    send_pixel('{8'd0,   8'd0,   8'd1});
    send_pixel('{8'd0,   8'd1,   8'd0});
    send_pixel('{8'd77,  8'd77,  8'd77});
    send_pixel('{8'd255, 8'd0,   8'd255});
    send_pixel('{8'd0,   8'd255, 8'd0});
    send_pixel('{8'd128, 8'd128, 8'd128});
  endtask

  // register extremes: clamped below two and above the maximum size
  task automatic test_size_extremes();
    // width clamps to the maximum: a full row, then the start of the odd row
    set_size(2047, 0);
    repeat (MAX_WIDTH + 4) send_pixel(rand_pixel());
    write_reg(REG_WIDTH, 4);
    finish_frame();
    // height far above the maximum, cut short by a smaller height
    set_size(1, 2047);
    repeat (20) send_pixel(rand_pixel());
    write_reg(REG_HEIGHT, 2);
    finish_frame();
    set_size(0, 1);
    send_frames(2);
  endtask

  // sizes reduced while the position lies beyond the new size
  task automatic test_mid_frame_shrink();
    set_size(12, 6);
    repeat (12 + 5) send_pixel(rand_pixel());
    write_reg(REG_WIDTH, 4);
    finish_frame();
    set_size(8, 8);
    repeat (8 * 5 + 3) send_pixel(rand_pixel());
    write_reg(REG_HEIGHT, 4);
    finish_frame();
  endtask

  // receiver stops for a long stretch while pixels keep coming
  task automatic test_backpressure();
    set_size(2, 2);
    hold_request = 1'b1;
    repeat (PRESSURE_ITEMS) send_pixel(rand_pixel());
  endtask

  // random sizes and content; some frames are resized part way through
  task automatic test_random();
    int start_count;
    int phase;
    int w;
    int h;
    int cut;
    start_count = pixels_sent;
    phase = 0;
    while (pixels_sent - start_count < RANDOM_ITEMS || phase < 3) begin
      // one phase with no gaps on either side
      no_idle = (phase == 2);
      w = $urandom_range(20, 0);
      h = $urandom_range(8, 0);
      set_size(w, h);
      if ($urandom_range(3) == 0) begin
        // cut in, narrow the width or redraw the height; widening reads stale pairs
        cut = $urandom_range(active_width() * active_height() - 1, 1);
        repeat (cut) send_pixel(rand_pixel());
        if ($urandom_range(1) == 0) write_reg(REG_WIDTH, $urandom_range(active_width(), 0));
        else write_reg(REG_HEIGHT, $urandom_range(10, 0));
        finish_frame();
      end else begin
        send_frames($urandom_range(2, 1));
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (even_row_sums[i]) even_row_sums[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_size_extremes();
    test_mid_frame_shrink();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
